>>> rtl/drpi_pkg.sv
// drpi_pkg: shared constants for the DR-sample parent index pipeline.
// No dependencies.
package drpi_pkg;

  localparam int NODE_W         = 32;  // node and parent index port width
  localparam int LVL_W          = 64;  // random word width
  localparam int INDEX_BITS_DEF = 32;  // default number of index bits used
  localparam int CHUNK_W        = 8;   // level bits reduced per modulo stage

endpackage

>>> rtl/drpi_log2.sv
// drpi_log2: first pipeline stage, bucket count floor(log2(j+1)).
// Depends on drpi_pkg.
module drpi_log2 import drpi_pkg::*; #(
  parameter int JW = 32,
  parameter int LW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  input  logic [JW-1:0] node,
  output logic          v_r,
  output logic          zero_r,
  output logic [LW-1:0] div_r,
  output logic [JW-1:0] j_r
);

  logic [JW:0]   jp1;
  logic [LW-1:0] lg;
  logic          zero_nxt;
  logic [LW-1:0] div_nxt;

  always_comb begin
    jp1 = {1'b0, node} + {{JW{1'b0}}, 1'b1};
    lg  = '0;
    for (int i = 1; i <= JW; i++) begin
      if (jp1[i]) begin
        lg = LW'(i);
      end
    end
    zero_nxt = (node == '0);
    // node zero has no bucket; divide by one so the modulo stays defined
    div_nxt  = zero_nxt ? LW'(1) : lg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    div_r  <= div_nxt;
    j_r    <= node;
  end

endmodule

>>> rtl/drpi_mod_stage.sv
// drpi_mod_stage: one stage of the restoring modulo, CHUNK_W level bits per stage.
// Depends on drpi_pkg.
module drpi_mod_stage import drpi_pkg::*; #(
  parameter int LW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_in,
  input  logic [LW-1:0]      div,
  input  logic [LW-1:0]      rem_in,
  input  logic [CHUNK_W-1:0] bits,
  output logic               v_r,
  output logic [LW-1:0]      rem_r
);

  logic [LW:0]   r;
  logic [LW-1:0] rem_nxt;

  always_comb begin
    r = {1'b0, rem_in};
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      r = {r[LW-1:0], bits[k]};
      // r < 2*div here, one subtract restores
      if (r >= {1'b0, div}) begin
        r = r - {1'b0, div};
      end
    end
    rem_nxt = r[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

endmodule

>>> rtl/drpi_parent.sv
// drpi_parent: last stage, offset and parent from bucket g (d = 2^g always).
// Depends on drpi_pkg.
module drpi_parent import drpi_pkg::*; #(
  parameter int JW = 32,
  parameter int LW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  input  logic          zero,
  input  logic [LW-1:0] g,
  input  logic [JW-1:0] j,
  input  logic [JW-1:0] ofs,
  output logic          v_r,
  output logic [JW-1:0] parent_r
);

  logic [JW-1:0] mask;
  logic [JW-1:0] om;
  logic [JW-1:0] add;
  logic [JW-1:0] parent_nxt;

  // g < floor(log2(j+1)) gives 2^g <= j, so min(j, 2^g) is 2^g
  always_comb begin
    mask = (JW'(1) << g) - JW'(1);
    om   = ofs & mask;
    add  = (g <= LW'(2)) ? JW'(2) : (JW'(1) << (g - LW'(1)));
    parent_nxt = zero ? '0 : (j - om - add + JW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    parent_r <= parent_nxt;
  end

endmodule

>>> rtl/drsample_parent_index.sv
// drsample_parent_index: second-parent selector of a depth-robust sampling graph.
// Pipeline: a taken request passes 1 log2 stage, 8 modulo stages of 8 level bits
// each and 1 parent stage, whose registered valid drives out_valid.
// Throughput: one request per cycle while not busy; busy rises in reset, then clears.
// Reset: synchronous active-low rst_n clears all valid bits; data regs are not reset.
// Depends on drpi_pkg, drpi_log2, drpi_mod_stage, drpi_parent.
module drsample_parent_index import drpi_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [NODE_W-1:0] in_node_index,
  input  logic [LVL_W-1:0]  in_rand_level,
  input  logic [LVL_W-1:0]  in_rand_offset,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_parent_index
);

  localparam int JW   = (INDEX_BITS < NODE_W) ? INDEX_BITS : NODE_W;
  localparam int LW   = $clog2(JW + 1);
  localparam int NSTG = LVL_W / CHUNK_W;

  logic          busy_r;
  logic          acc;
  logic          v_p    [0:NSTG];
  logic          z_p    [0:NSTG];
  logic [LW-1:0] div_p  [0:NSTG];
  logic [JW-1:0] j_p    [0:NSTG];
  logic [LW-1:0] rem_p  [0:NSTG];
  logic [JW-1:0] ofs_p  [0:NSTG];
  logic [LVL_W-1:0] lvl_p [0:NSTG-1];
  logic [JW-1:0] par;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = start & ~busy_r;

  drpi_log2 #(.JW(JW), .LW(LW)) u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_in   (acc),
    .node   (in_node_index[JW-1:0]),
    .v_r    (v_p[0]),
    .zero_r (z_p[0]),
    .div_r  (div_p[0]),
    .j_r    (j_p[0])
  );

  always_ff @(posedge clk) begin
    lvl_p[0] <= in_rand_level;
    ofs_p[0] <= in_rand_offset[JW-1:0];
  end

  assign rem_p[0] = '0;

  for (genvar k = 1; k <= NSTG; k++) begin : g_mod
    drpi_mod_stage #(.LW(LW)) u_mod (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (v_p[k-1]),
      .div    (div_p[k-1]),
      .rem_in (rem_p[k-1]),
      .bits   (lvl_p[k-1][LVL_W-1-(k-1)*CHUNK_W -: CHUNK_W]),
      .v_r    (v_p[k]),
      .rem_r  (rem_p[k])
    );

    always_ff @(posedge clk) begin
      z_p[k]   <= z_p[k-1];
      div_p[k] <= div_p[k-1];
      j_p[k]   <= j_p[k-1];
      ofs_p[k] <= ofs_p[k-1];
    end

    if (k < NSTG) begin : g_lvl
      always_ff @(posedge clk) begin
        lvl_p[k] <= lvl_p[k-1];
      end
    end
  end

  drpi_parent #(.JW(JW), .LW(LW)) u_parent (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (v_p[NSTG]),
    .zero     (z_p[NSTG]),
    .g        (rem_p[NSTG]),
    .j        (j_p[NSTG]),
    .ofs      (ofs_p[NSTG]),
    .v_r      (out_valid),
    .parent_r (par)
  );

  assign out_parent_index = NODE_W'(par);

`ifndef SYNTHESIS
  a_busy_in_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n) acc |=> v_p[0])
    else $error("request lost at pipeline entry");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_p[NSTG] |-> (rem_p[NSTG] < div_p[NSTG]))
    else $error("bucket not below bucket count");
  a_parent_below: assert property (@(posedge clk) disable iff (!rst_n)
    v_p[NSTG] |=> ((par < $past(j_p[NSTG])) || $past(z_p[NSTG])))
    else $error("parent not earlier than node");
`endif

endmodule
